/* rtl/sitda_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and helpers for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int unsigned VALUE_W   = 55;
   localparam int unsigned MAG_W     = 54;
   localparam int unsigned DIGITS    = 16;
   localparam int unsigned BCD_W     = 4 * DIGITS;
   localparam int unsigned STAGES    = 9;
   localparam int unsigned BITS_STEP = MAG_W / STAGES;
   localparam int unsigned IDX_W     = 4;
   localparam int unsigned CHAR_W    = 6;

   localparam logic [VALUE_W-1:0] SAFE_MAX   = 55'd9007199254740992;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;

   typedef logic [BCD_W-1:0] bcd_type;

   // one shift-and-add-3 step of binary to bcd conversion
   function automatic bcd_type dd_step(input bcd_type bcd, input logic in_bit);
      bcd_type adj;
      adj = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (adj[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], in_bit};
   endfunction

endpackage
`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ascii text, one character a word.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one signed 55-bit value per word (req_valid/req_ready).
//   rsp_ channel: one character per word, '-' first for negative values,
//   then the digits most significant first without leading zeros; rsp_last
//   marks the final character. Magnitudes above 2^53 saturate to 2^53.
//   Path: a value passes an input register and nine double-dabble stages
//   (six bits each), is loaded into the serializer and its first character
//   then appears in the output register.
//   Throughput: the conversion pipeline takes a value every cycle unless
//   stalled; the serializer emits one character per cycle while the output
//   slot is free and loads a new value only after its last character.
//   Reset (synchronous, active high) clears all valid bits, the serializer
//   busy flag and rsp_valid; the data registers are not reset.
//   When the receiver stalls the output register holds its word, the
//   serializer waits, and the pipeline stops once its last stage is full,
//   dropping req_ready. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  signed [sitda_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [sitda_pkg::CHAR_W-1:0] rsp_ascii_char,
   output logic                         rsp_last
);

   localparam int unsigned NS = sitda_pkg::STAGES;

   // conversion pipeline, stage 0 is the input register
   logic                         v_ff   [0:NS];
   logic                         neg_ff [0:NS];
   logic [sitda_pkg::MAG_W-1:0]  bin_ff [0:NS];
   sitda_pkg::bcd_type           bcd_ff [0:NS];
   sitda_pkg::bcd_type           bcd_in [1:NS];
   logic [sitda_pkg::MAG_W-1:0]  bin_in [1:NS];

   logic                         en;
   logic                         take;
   logic [sitda_pkg::VALUE_W-1:0] mag_full;
   logic [sitda_pkg::MAG_W-1:0]  mag_sat;

   // serializer and output register
   logic                         busy_ff, busy_in;
   logic                         sign_ff, sign_in;
   logic [sitda_pkg::IDX_W-1:0]  idx_ff, idx_in;
   sitda_pkg::bcd_type           dig_ff, dig_in;
   logic                         ov_ff, ov_in;
   logic [sitda_pkg::CHAR_W-1:0] och_ff, och_in;
   logic                         olast_ff, olast_in;
   logic [sitda_pkg::IDX_W-1:0]  top;
   logic                         slot_free;

   assign take      = v_ff[NS] && !busy_ff;
   assign en        = !v_ff[NS] || take;
   assign req_ready = en;

   always_comb begin
      mag_full = req_value[sitda_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;
      if (mag_full > sitda_pkg::SAFE_MAX) begin
         mag_sat = sitda_pkg::SAFE_MAX[sitda_pkg::MAG_W-1:0];
      end else begin
         mag_sat = mag_full[sitda_pkg::MAG_W-1:0];
      end
   end

   always_comb begin
      for (int s = 1; s <= NS; s++) begin
         bcd_in[s] = bcd_ff[s-1];
         bin_in[s] = bin_ff[s-1];
         for (int k = 0; k < sitda_pkg::BITS_STEP; k++) begin
            bcd_in[s] = sitda_pkg::dd_step(bcd_in[s], bin_in[s][sitda_pkg::MAG_W-1]);
            bin_in[s] = {bin_in[s][sitda_pkg::MAG_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NS; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int s = 1; s <= NS; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= req_value[sitda_pkg::VALUE_W-1];
         bin_ff[0] <= mag_sat;
         bcd_ff[0] <= '0;
         for (int s = 1; s <= NS; s++) begin
            neg_ff[s] <= neg_ff[s-1];
            bin_ff[s] <= bin_in[s];
            bcd_ff[s] <= bcd_in[s];
         end
      end
   end

   // position of the leading nonzero digit, zero for the value zero
   always_comb begin
      top = '0;
      for (int i = 0; i < sitda_pkg::DIGITS; i++) begin
         if (bcd_ff[NS][4*i +: 4] != 4'd0) begin
            top = sitda_pkg::IDX_W'(i);
         end
      end
   end

   assign slot_free = !ov_ff || rsp_ready;

   always_comb begin
      busy_in  = busy_ff;
      sign_in  = sign_ff;
      idx_in   = idx_ff;
      dig_in   = dig_ff;
      ov_in    = ov_ff && !rsp_ready;
      och_in   = och_ff;
      olast_in = olast_ff;
      if (take) begin
         busy_in = 1'b1;
         sign_in = neg_ff[NS];
         idx_in  = top;
         dig_in  = bcd_ff[NS];
      end else if (busy_ff && slot_free) begin
         ov_in = 1'b1;
         if (sign_ff) begin
            och_in   = sitda_pkg::CHAR_MINUS;
            olast_in = 1'b0;
            sign_in  = 1'b0;
         end else begin
            och_in   = sitda_pkg::CHAR_ZERO + {2'b00, dig_ff[4*idx_ff +: 4]};
            olast_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff  <= sign_in;
      idx_ff   <= idx_in;
      dig_ff   <= dig_in;
      och_ff   <= och_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid      = ov_ff;
   assign rsp_ascii_char = och_ff;
   assign rsp_last       = olast_ff;

endmodule
`default_nettype wire

/* tb/signed_int_to_decimal_ascii_tb.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed values into the converter, predicts the decimal text of each
// and checks every character and its last flag in order.
// ----------------------------------------------------------------------------
class char_scoreboard;
   logic [5:0] exp_char[$];
   logic       exp_last[$];
   int         errors;

   // expected text of one accepted value
   function void note_value(logic signed [54:0] v);
      logic [54:0]      mag;
      logic [54:0]      lim;
      logic [3:0]       digs[$];
      lim = 55'd9999999999999999;
      if (lim > 55'd9007199254740992) lim = 55'd9007199254740992;
      mag = v[54] ? -v : v;
      if (mag > lim) mag = lim;
      if (mag == 0) begin
         exp_char.push_back(6'd48);
         exp_last.push_back(1'b1);
         return;
      end
      while (mag != 0) begin
         digs.push_front(4'(mag % 10));
         mag = mag / 10;
      end
      if (v[54]) begin
         exp_char.push_back(6'd45);
         exp_last.push_back(1'b0);
      end
      foreach (digs[i]) begin
         exp_char.push_back(6'd48 + 6'(digs[i]));
         exp_last.push_back(i == digs.size() - 1);
      end
   endfunction

   function void check_char(logic [5:0] c, logic l);
      logic [5:0] ec;
      logic       el;
      if (exp_char.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected word: char %0d last %0d", c, l);
         return;
      end
      ec = exp_char.pop_front();
      el = exp_last.pop_front();
      if (ec !== c || el !== l) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected char %0d last %0d, got char %0d last %0d",
                     ec, el, c, l);
      end
   endfunction

   function int pending();
      return exp_char.size();
   endfunction
endclass

module signed_int_to_decimal_ascii_tb;
   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [54:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [5:0]         rsp_ascii_char;
   logic               rsp_last;

   char_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  hold_off = 0;
   bit  stim_done = 0;

   signed_int_to_decimal_ascii dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_ascii_char(rsp_ascii_char), .rsp_last(rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // offer one word and wait until it is taken
   task automatic send_value(logic signed [54:0] v);
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_value(v);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [54:0] rand_value();
      logic [54:0] r;
      int          sel;
      sel = $urandom_range(0, 9);
      r = 55'({$urandom, $urandom});
      case (sel)
         0: r = 55'($urandom_range(0, 99));
         1: r = 55'($urandom_range(0, 100000));
         2: r = r >> $urandom_range(0, 54);
         3: r = 55'd9007199254740992 - 55'($urandom_range(0, 3));
         default: r = r >> $urandom_range(0, 2);
      endcase
      if ($urandom_range(0, 1)) r = -r;
      return r;
   endfunction

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int ph;
      ph = 0;
      forever begin
         @(posedge clock);
         ph++;
         if (hold_off) rsp_ready <= 1'b0;
         else if (ph % 200 < 60) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_char(rsp_ascii_char, rsp_last);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic signed [54:0] dir[$];
      int burst;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir = '{0, 1, -1, 9, -9, 10, -10, 12345, -98765,
              55'sd9007199254740992, -55'sd9007199254740992,
              55'sd9007199254740991, -55'sd9007199254740991,
              55'sd9007199254740993, -55'sd9007199254740993,
              55'sd9999999999999999, 55'sd18014398509481983,
              -55'sd18014398509481984, -55'sd18014398509481983,
              55'sd999999999999999, 55'sd1000000000000000, 55'h2AAAAAAAAAAAAA,
              55'h55555555555555};
      foreach (dir[i]) send_value(dir[i]);

      // long receiver hold-off while words keep coming
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int i = 0; i < 30; i++) send_value(rand_value());
         end
      join
      drop_valid();
      // sender pause until everything has drained
      while (sb.pending() != 0) @(posedge clock);

      n = 0;
      while (n < 260) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst; i++) begin
            send_value(rand_value());
            n++;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
      drop_valid();
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
